/* src/fud_pkg.sv */
// Shared types and constants for the form-urlencoded stream decoder.
package fud_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Output queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Words produced by one input byte, first in b0
    typedef struct packed {
        logic [1:0] num;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_dec_res;

endpackage

/* src/form_urlencoded_stream_decoder.sv */
// Top level: form-urlencoded byte stream decoder.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------
//  input   | i_valid | o_stall | i_in_byte
//  output  | o_valid | i_stall | o_out_byte
//
// One input word per cycle enters the input register while o_stall is low;
// once the queue has room it decodes into 0..2 words for a four-entry queue.
// Throughput is one input word per cycle while the queue keeps two free slots;
// the output port (one word per cycle while i_stall is low) sets the long-run
// rate when bytes expand into two words.
// Reset (i_rst_n, synchronous, active low) clears parser flags and the queue.
// A stall on the output backs up through the queue to o_stall.
module form_urlencoded_stream_decoder import fud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic       room;
    logic       adv;
    t_dec_res   res;

    // the held word decodes once the queue can take its worst case of two
    assign adv     = r_in_valid && room;
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    fud_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    fud_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .o_room     (room),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte)
    );

    // a word held in the input register only waits for queue space
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && !room))
        else $error("input stalled without cause");

    // a stalled input word stays held, unchanged, in the input register
    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input word lost under stall");

endmodule

/* src/fud_core.sv */
// Parser state and single-byte decode logic.
module fud_core import fud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_byte,
    output t_dec_res   o_res
);

    logic       r_in_value_part, n_in_value_part;
    logic       r_key_nonempty,  n_key_nonempty;
    logic       r_escape_pending, n_escape_pending;
    logic       r_digit_held,    n_digit_held;
    logic [3:0] r_held_nibble,   n_held_nibble;

    logic       is_hex;
    logic [3:0] hex_v;
    logic [7:0] flush_v;
    logic       en;

    always_comb begin
        is_hex = 1'b1;
        hex_v  = 4'd0;
        if (i_byte inside {[8'h30:8'h39]}) begin
            hex_v = 4'(i_byte - 8'h30);
        end else if (i_byte inside {[8'h41:8'h46]}) begin
            hex_v = 4'(i_byte - 8'h37);
        end else if (i_byte inside {[8'h61:8'h66]}) begin
            hex_v = 4'(i_byte - 8'h57);
        end else begin
            is_hex = 1'b0;
        end
    end

    assign flush_v = r_digit_held ? {4'd0, r_held_nibble} : CH_PCT;

    always_comb begin
        n_in_value_part  = r_in_value_part;
        n_key_nonempty   = r_key_nonempty;
        n_escape_pending = r_escape_pending;
        n_digit_held     = r_digit_held;
        n_held_nibble    = r_held_nibble;
        o_res            = '0;
        en               = 1'b0;

        if (i_byte == CH_NUL || i_byte == CH_AMP) begin
            // pair end: flushed escape then marker, only for a non-empty key
            if (r_key_nonempty) begin
                if (r_escape_pending) begin
                    o_res.num = 2'd2;
                    o_res.b0  = flush_v;
                    o_res.b1  = CH_NUL;
                end else begin
                    o_res.num = 2'd1;
                    o_res.b0  = CH_NUL;
                end
            end
            n_in_value_part  = 1'b0;
            n_key_nonempty   = 1'b0;
            n_escape_pending = 1'b0;
            n_digit_held     = 1'b0;
            n_held_nibble    = 4'd0;
        end else if (i_byte == CH_EQ && !r_in_value_part) begin
            if (r_key_nonempty && r_escape_pending) begin
                o_res.num = 2'd1;
                o_res.b0  = flush_v;
            end
            n_in_value_part  = 1'b1;
            n_escape_pending = 1'b0;
            n_digit_held     = 1'b0;
            n_held_nibble    = 4'd0;
        end else begin
            en             = r_key_nonempty | ~r_in_value_part;
            n_key_nonempty = en;
            if (i_byte == CH_PCT) begin
                if (r_escape_pending && en) begin
                    o_res.num = 2'd1;
                    o_res.b0  = flush_v;
                end
                n_escape_pending = 1'b1;
                n_digit_held     = 1'b0;
                n_held_nibble    = 4'd0;
            end else if (is_hex && r_escape_pending && i_byte != CH_PLUS) begin
                if (r_digit_held) begin
                    if (en) begin
                        o_res.num = 2'd1;
                        o_res.b0  = {r_held_nibble, hex_v};
                    end
                    n_escape_pending = 1'b0;
                    n_digit_held     = 1'b0;
                    n_held_nibble    = 4'd0;
                end else begin
                    n_digit_held  = 1'b1;
                    n_held_nibble = hex_v;
                end
            end else begin
                // '+' or plain byte, after any pending escape
                if (en) begin
                    if (r_escape_pending) begin
                        o_res.num = 2'd2;
                        o_res.b0  = flush_v;
                        o_res.b1  = (i_byte == CH_PLUS) ? CH_SPACE : i_byte;
                    end else begin
                        o_res.num = 2'd1;
                        o_res.b0  = (i_byte == CH_PLUS) ? CH_SPACE : i_byte;
                    end
                end
                n_escape_pending = 1'b0;
                n_digit_held     = 1'b0;
                n_held_nibble    = 4'd0;
            end
        end
        if (!i_adv) begin
            o_res.num = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value_part  <= 1'b0;
            r_key_nonempty   <= 1'b0;
            r_escape_pending <= 1'b0;
            r_digit_held     <= 1'b0;
            r_held_nibble    <= 4'd0;
        end else if (i_adv) begin
            r_in_value_part  <= n_in_value_part;
            r_key_nonempty   <= n_key_nonempty;
            r_escape_pending <= n_escape_pending;
            r_digit_held     <= n_digit_held;
            r_held_nibble    <= n_held_nibble;
        end
    end

    a_digit_needs_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_held |-> r_escape_pending)
        else $error("digit held with no escape pending");

    a_pair_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (i_byte == CH_NUL || i_byte == CH_AMP)) |=>
            (!r_in_value_part && !r_key_nonempty && !r_escape_pending))
        else $error("pair end left parser state behind");

endmodule

/* src/fud_fifo.sv */
// Small output queue taking up to two decoded words per cycle.
module fud_fifo import fud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dec_res   i_res,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte
);

    logic [7:0]     r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_count;
    logic           pop;
    logic [QAW-1:0] wp1;

    assign o_room     = r_count <= QCW'(QDEPTH - 2);
    assign o_valid    = r_count != '0;
    assign o_out_byte = r_mem[r_rp];
    assign pop        = o_valid && !i_stall;
    assign wp1        = r_wp + QAW'(1);

    always_ff @(posedge i_clk) begin
        if (i_res.num != 2'd0) begin
            r_mem[r_wp] <= i_res.b0;
        end
        if (i_res.num == 2'd2) begin
            r_mem[wp1] <= i_res.b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + QAW'(i_res.num);
            r_rp    <= r_rp + QAW'(pop);
            r_count <= r_count + QCW'(i_res.num) - QCW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("output queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(r_count) + QCW'($past(i_res.num))
                                      - QCW'($past(pop)))
        else $error("queue count out of step");

endmodule

/* test/form_urlencoded_stream_decoder_tb.sv */
// Self-checking testbench for the form-urlencoded stream decoder.
module form_urlencoded_stream_decoder_tb import fud_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS   = 950;   // input words in the random part
    localparam int HOLD_CYCLES  = 300;   // long output hold-off
    localparam int DRAIN_LIMIT  = 5000;  // cycles allowed for the tail to drain
    localparam int SETTLE_CYCLES = 16;   // extra cycles after the last word

    // One directed stimulus row.  typed=1 means the expected words are given
    // here; otherwise the predictor works them out.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       typed;
        logic [1:0] num;
        logic [7:0] w0;
        logic [7:0] w1;
    } t_dir_row;

    localparam int DIR_ROWS = 26;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{CH_NUL,   1'b1, 2'd0, 8'h00,  8'h00},  // terminator with empty key: silent
        '{8'h61,    1'b1, 2'd1, 8'h61,  8'h00},  // hex letter outside an escape: literal
        '{CH_PCT,   1'b0, 2'd0, 8'h00,  8'h00},
        '{8'h34,    1'b0, 2'd0, 8'h00,  8'h00},
        '{8'h67,    1'b0, 2'd0, 8'h00,  8'h00},  // non-hex after one digit: nibble then 'g'
        '{CH_EQ,    1'b0, 2'd0, 8'h00,  8'h00},  // key/value boundary
        '{8'hFF,    1'b1, 2'd1, 8'hFF,  8'h00},  // top of the byte range
        '{CH_PLUS,  1'b1, 2'd1, CH_SPACE, 8'h00},
        '{CH_EQ,    1'b0, 2'd0, 8'h00,  8'h00},  // later '=' is literal
        '{CH_PCT,   1'b0, 2'd0, 8'h00,  8'h00},
        '{CH_PCT,   1'b0, 2'd0, 8'h00,  8'h00},  // percent inside an escape
        '{8'h34,    1'b0, 2'd0, 8'h00,  8'h00},
        '{8'h31,    1'b0, 2'd0, 8'h00,  8'h00},  // full %41
        '{CH_PCT,   1'b0, 2'd0, 8'h00,  8'h00},
        '{CH_PLUS,  1'b0, 2'd0, 8'h00,  8'h00},  // lone percent flushed by '+'
        '{CH_PCT,   1'b0, 2'd0, 8'h00,  8'h00},
        '{8'h41,    1'b0, 2'd0, 8'h00,  8'h00},
        '{CH_AMP,   1'b0, 2'd0, 8'h00,  8'h00},  // pair end flushes held nibble
        '{CH_EQ,    1'b0, 2'd0, 8'h00,  8'h00},  // empty raw key
        '{8'h78,    1'b0, 2'd0, 8'h00,  8'h00},
        '{CH_AMP,   1'b1, 2'd0, 8'h00,  8'h00},  // dropped pair: no marker
        '{8'h6B,    1'b0, 2'd0, 8'h00,  8'h00},
        '{CH_PCT,   1'b0, 2'd0, 8'h00,  8'h00},
        '{8'h46,    1'b0, 2'd0, 8'h00,  8'h00},
        '{CH_EQ,    1'b0, 2'd0, 8'h00,  8'h00},  // '=' flushes the key escape
        '{CH_NUL,   1'b1, 2'd1, 8'h00,  8'h00}   // terminator closes the pair
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;

    form_urlencoded_stream_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte)
    );

    // Parser state mirrored by the predictor
    logic       pr_in_value;
    logic       pr_key_nonempty;
    logic       pr_escape;
    logic       pr_digit_held;
    logic [3:0] pr_nibble;

    logic [7:0] pending_words[$];   // decoded words still due on the output
    logic [7:0] form_bytes[$];      // raw form text waiting to be sent

    int mismatches;
    int words_checked;
    int pairs_closed;
    int words_sent;
    int input_stall_cycles;
    int src_idle_pct;
    int sink_idle_pct;
    bit hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("[%0t] %s: got %02h, want %02h", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic void clear_parser();
        pr_in_value     = 1'b0;
        pr_key_nonempty = 1'b0;
        pr_escape       = 1'b0;
        pr_digit_held   = 1'b0;
        pr_nibble       = 4'h0;
    endfunction

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
        if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
        if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
        return -1;
    endfunction

    function automatic t_dec_res add_word(input t_dec_res r, input logic [7:0] v);
        if (r.num == 2'd0) r.b0 = v;
        else               r.b1 = v;
        r.num = r.num + 2'd1;
        return r;
    endfunction

    // Resolve a pending escape: held nibble if a digit came, else '%'.
    // The escape is cleared whether or not the word is kept.
    function automatic t_dec_res flush_escape(input t_dec_res r, input logic keep);
        if (pr_escape) begin
            if (keep)
                r = add_word(r, pr_digit_held ? {4'h0, pr_nibble} : CH_PCT);
            pr_escape     = 1'b0;
            pr_digit_held = 1'b0;
            pr_nibble     = 4'h0;
        end
        return r;
    endfunction

    function automatic t_dec_res decode_byte(input logic [7:0] b);
        t_dec_res r;
        logic     keep;
        int       h;
        r = '0;
        h = hex_digit(b);
        if (b == CH_NUL || b == CH_AMP) begin
            if (pr_key_nonempty) begin
                r = flush_escape(r, 1'b1);
                r = add_word(r, CH_NUL);
                pairs_closed++;
            end
            clear_parser();
            return r;
        end
        if (b == CH_EQ && !pr_in_value) begin
            r = flush_escape(r, pr_key_nonempty);
            pr_in_value = 1'b1;
            return r;
        end
        if (!pr_in_value)
            pr_key_nonempty = 1'b1;
        keep = pr_key_nonempty;
        if (b == CH_PLUS) begin
            r = flush_escape(r, keep);
            if (keep) r = add_word(r, CH_SPACE);
        end else if (b == CH_PCT) begin
            r = flush_escape(r, keep);
            pr_escape     = 1'b1;
            pr_digit_held = 1'b0;
            pr_nibble     = 4'h0;
        end else if (h >= 0 && pr_escape) begin
            if (pr_digit_held) begin
                if (keep) r = add_word(r, {pr_nibble, h[3:0]});
                pr_escape     = 1'b0;
                pr_digit_held = 1'b0;
                pr_nibble     = 4'h0;
            end else begin
                pr_digit_held = 1'b1;
                pr_nibble     = h[3:0];
            end
        end else begin
            r = flush_escape(r, keep);
            if (keep) r = add_word(r, b);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Random form text
    // ---------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + {4'h0, v};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] plain_char();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(8'h61, 8'h7A));
            1:       return 8'($urandom_range(8'h41, 8'h5A));
            default: return 8'($urandom_range(8'h30, 8'h39));
        endcase
    endfunction

    function automatic void add_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            form_bytes.push_back(plain_char());
        end else if (r < 60) begin
            form_bytes.push_back(CH_PCT);
            form_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
            form_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        end else if (r < 68) begin
            form_bytes.push_back(CH_PLUS);
        end else if (r < 76) begin
            // broken escape: at most one digit, then whatever follows
            form_bytes.push_back(CH_PCT);
            if ($urandom_range(0, 1))
                form_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
            case ($urandom_range(0, 4))
                1: form_bytes.push_back(8'($urandom_range(8'h67, 8'h7A)));
                2: form_bytes.push_back(CH_PLUS);
                3: form_bytes.push_back(CH_PCT);
                4: form_bytes.push_back(CH_EQ);
                default: ;
            endcase
        end else if (r < 82) begin
            form_bytes.push_back(CH_EQ);
        end else begin
            form_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    // Mostly well-formed pairs; one in ten is a burst of raw noise.
    function automatic void add_pair();
        int klen;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
                form_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        klen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
        repeat (klen) add_token();
        if ($urandom_range(0, 9) != 0) begin
            form_bytes.push_back(CH_EQ);
            repeat ($urandom_range(0, 5)) add_token();
        end
        form_bytes.push_back(($urandom_range(0, 6) == 0) ? CH_NUL : CH_AMP);
    endfunction

    // ---------------------------------------------------------------------
    // Input side: called and returns at a falling edge
    // ---------------------------------------------------------------------
    task automatic send_word(input t_dir_row row);
        t_dec_res r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= row.in_byte;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // word accepted at this edge
        r = decode_byte(row.in_byte);
        if (row.typed) begin
            r.num = row.num;
            r.b0  = row.w0;
            r.b1  = row.w1;
        end
        if (r.num >= 2'd1) pending_words.push_back(r.b0);
        if (r.num >= 2'd2) pending_words.push_back(r.b1);
        words_sent++;
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Output side: random stall plus one long hold-off on request
    // ---------------------------------------------------------------------
    initial begin : sink
        int hold;
        hold    = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold == 0) begin
                hold     = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < sink_idle_pct);
            end
        end
    end

    // Output checker: in-order compare against the predicted words
    always @(posedge i_clk) begin : out_check
        logic [7:0] want;
        if (i_rst_n && i_valid && o_stall)
            input_stall_cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing expected", o_out_byte, 8'h00);
            end else begin
                want = pending_words.pop_front();
                if (o_out_byte !== want)
                    report_mismatch("out_byte", o_out_byte, want);
                words_checked++;
            end
        end
    end

    // Hard stop well beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        t_dir_row row;
        int       waited;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_in_byte          = 8'h00;
        hold_req           = 1'b0;
        mismatches         = 0;
        words_checked      = 0;
        pairs_closed       = 0;
        words_sent         = 0;
        input_stall_cycles = 0;
        src_idle_pct       = 20;
        sink_idle_pct      = 20;
        clear_parser();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
            send_word(DIR_TABLE[i]);

        // random part; idle-free stretch in the middle, long hold-off later
        row = '0;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == 350) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else if (i == 550) begin
                src_idle_pct  = 20;
                sink_idle_pct = 20;
            end else if (i == 700) begin
                hold_req = 1'b1;   // sender keeps going; queue fills and stalls us
            end
            if (form_bytes.size() == 0) add_pair();
            row.in_byte = form_bytes.pop_front();
            send_word(row);
        end
        i_valid <= 1'b0;

        waited = 0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending_words.size() != 0)
            report_mismatch("word never arrived", 8'h00, pending_words.pop_front());

        $display("Sent %0d form bytes (directed table, random pairs, noise bursts).",
                 words_sent);
        $display("Checked %0d decoded words over %0d closed pairs; input stalled %0d cycles.",
                 words_checked, pairs_closed, input_stall_cycles);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
src/fud_pkg.sv
src/fud_core.sv
src/fud_fifo.sv
src/form_urlencoded_stream_decoder.sv
test/form_urlencoded_stream_decoder_tb.sv
